// ----- rtl/core/cm6_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the symbol-to-character map for the CM6 sample encoder.
// Has no dependencies; every other file in rtl/core refers to it by scoped names.

package cm6_pkg;

  localparam logic [26:0] MAXMAG    = 27'h7ffffff;
  localparam logic [33:0] LIM_N2    = 34'h0000_0010;
  localparam logic [33:0] LIM_N3    = 34'h0000_0200;
  localparam logic [33:0] LIM_N4    = 34'h0000_4000;
  localparam logic [33:0] LIM_N5    = 34'h0008_0000;
  localparam logic [33:0] LIM_N6    = 34'h0100_0000;
  localparam logic [1:0]  REG_DIFF_ORDER   = 2'd0;
  localparam logic [1:0]  REG_CLIP_ENABLE  = 2'd1;
  localparam logic [1:0]  REG_OUTPUT_LIMIT = 2'd2;
  localparam logic [1:0]  ORDER_NONE  = 2'd0;
  localparam logic [1:0]  ORDER_FIRST = 2'd1;
  localparam logic [30:0] LIMIT_RESET = 31'h7fffffff;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               block_start;
    logic               block_end;
  } samp_item_t;

  typedef struct packed {
    logic [6:0] code_char;
    logic       sample_last;
    logic       block_last;
    logic       overflow;
  } code_item_t;

  typedef struct packed {
    logic [1:0]  diff_order;
    logic        clip_enable;
    logic [30:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic        sign;
    logic [26:0] mag;
    logic [2:0]  last_idx;
    logic        ovf;
    logic        block_end;
  } job_t;

  function automatic logic [6:0] cm6_char(input logic [5:0] sym);
    logic [6:0] c;
    if (sym == 6'd0) begin
      c = 7'd43;
    end else if (sym == 6'd1) begin
      c = 7'd45;
    end else if (sym < 6'd12) begin
      c = 7'(sym) + 7'd46;
    end else if (sym < 6'd38) begin
      c = 7'(sym) + 7'd53;
    end else begin
      c = 7'(sym) + 7'd59;
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/cm6_front.sv -----
`timescale 1ns / 1ps
// Front end: clipping, differencing, magnitude classification and byte budget check.
// Uses cm6_pkg; pushes one job per sample into the queue.

module cm6_front (
  input  logic              clk,
  input  logic              rst,
  input  cm6_pkg::cfg_t     cfg,
  input  logic              samp_valid,
  output logic              samp_stall,
  input  cm6_pkg::samp_item_t samp_item,
  input  logic              q_full,
  output logic              q_push,
  output cm6_pkg::job_t     q_job
);

  logic               en;
  logic               s1_valid;
  logic signed [31:0] s1_x;
  logic               s1_start;
  logic               s1_end;
  logic               s2_valid;
  logic signed [33:0] s2_v;
  logic               s2_start;
  logic               s2_end;
  logic signed [31:0] prev_sample;
  logic signed [31:0] prev_diff;
  logic [30:0]        bytes;
  logic               ovf_seen;

  logic signed [31:0] x_clip;
  logic signed [31:0] ps;
  logic signed [31:0] pd;
  logic signed [32:0] diff;
  logic signed [31:0] d1;
  logic signed [33:0] dd;
  logic signed [33:0] v;
  logic [33:0]        mag;
  logic [2:0]         last_idx;
  logic [30:0]        bytes_base;
  logic               ovf_base;
  logic [31:0]        sum;
  logic               over;

  assign en         = !q_full;
  assign samp_stall = q_full;
  assign q_push     = en && s2_valid;

  always_comb begin
    x_clip = samp_item.sample;
    if (cfg.clip_enable) begin
      if (samp_item.sample > $signed({5'd0, cm6_pkg::MAXMAG})) begin
        x_clip = $signed({5'd0, cm6_pkg::MAXMAG});
      end else if (samp_item.sample < -$signed({5'd0, cm6_pkg::MAXMAG})) begin
        x_clip = -$signed({5'd0, cm6_pkg::MAXMAG});
      end
    end
  end

  always_comb begin
    ps   = s1_start ? '0 : prev_sample;
    pd   = s1_start ? '0 : prev_diff;
    diff = {s1_x[31], s1_x} - {ps[31], ps};
    if (diff[32] != diff[31]) begin
      d1 = diff[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      d1 = diff[31:0];
    end
    dd = {{2{d1[31]}}, d1} - {{2{pd[31]}}, pd};
    case (cfg.diff_order)
      cm6_pkg::ORDER_NONE:  v = {{2{s1_x[31]}}, s1_x};
      cm6_pkg::ORDER_FIRST: v = {{2{d1[31]}}, d1};
      default:              v = dd;
    endcase
  end

  always_comb begin
    mag = s2_v[33] ? (34'd0 - s2_v) : s2_v;
    if (mag < cm6_pkg::LIM_N2) begin
      last_idx = 3'd0;
    end else if (mag < cm6_pkg::LIM_N3) begin
      last_idx = 3'd1;
    end else if (mag < cm6_pkg::LIM_N4) begin
      last_idx = 3'd2;
    end else if (mag < cm6_pkg::LIM_N5) begin
      last_idx = 3'd3;
    end else if (mag < cm6_pkg::LIM_N6) begin
      last_idx = 3'd4;
    end else begin
      last_idx = 3'd5;
    end
    bytes_base = s2_start ? '0 : bytes;
    ovf_base   = s2_start ? 1'b0 : ovf_seen;
    sum        = {1'b0, bytes_base} + 32'(last_idx) + 32'd1;
    over       = ovf_base || (sum > {1'b0, cfg.output_limit});
    q_job.sign      = s2_v[33];
    q_job.mag       = (mag > {7'd0, cm6_pkg::MAXMAG}) ? cm6_pkg::MAXMAG : mag[26:0];
    q_job.last_idx  = last_idx;
    q_job.ovf       = over;
    q_job.block_end = s2_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      prev_sample <= '0;
      prev_diff   <= '0;
      bytes       <= '0;
      ovf_seen    <= 1'b0;
    end else if (en) begin
      s1_valid <= samp_valid;
      s2_valid <= s1_valid;
      if (s1_valid) begin
        prev_sample <= s1_x;
        prev_diff   <= d1;
      end
      if (s2_valid) begin
        ovf_seen <= over;
        bytes    <= over ? bytes_base : sum[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (samp_valid) begin
        s1_x     <= x_clip;
        s1_start <= samp_item.block_start;
        s1_end   <= samp_item.block_end;
      end
      if (s1_valid) begin
        s2_v     <= v;
        s2_start <= s1_start;
        s2_end   <= s1_end;
      end
    end
  end

endmodule

// ----- rtl/core/cm6_queue.sv -----
`timescale 1ns / 1ps
// Small job queue between the front end and the symbol emitter.
// Uses cm6_pkg for the job type.

module cm6_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cm6_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output cm6_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cm6_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/core/cm6_back.sv -----
`timescale 1ns / 1ps
// Back end: walks a queued job one six-bit symbol per cycle, when not stalled, into the output register.
// Uses cm6_pkg for the job and result types and the character map.

module cm6_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  cm6_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               code_valid,
  input  logic               code_stall,
  output cm6_pkg::code_item_t code_item
);

  logic          cur_valid;
  cm6_pkg::job_t cur;
  logic [2:0]    rem;
  logic          first;
  logic          out_ready;
  logic          emit;
  logic          last;
  logic [4:0]    chunk;
  logic [5:0]    sym;
  cm6_pkg::code_item_t res;

  assign out_ready = !code_valid || !code_stall;
  assign emit      = cur_valid && out_ready;
  assign last      = cur.ovf || (rem == 3'd0);
  assign q_pop     = q_nonempty && (!cur_valid || (emit && last));

  always_comb begin
    case (rem)
      3'd0:    chunk = cur.mag[4:0];
      3'd1:    chunk = cur.mag[9:5];
      3'd2:    chunk = cur.mag[14:10];
      3'd3:    chunk = cur.mag[19:15];
      3'd4:    chunk = cur.mag[24:20];
      3'd5:    chunk = {3'd0, cur.mag[26:25]};
      default: chunk = '0;
    endcase
    sym[5] = (rem != 3'd0);
    if (first) begin
      sym[4:0] = {cur.sign, chunk[3:0]};
    end else begin
      sym[4:0] = chunk;
    end
    if (cur.ovf) begin
      res.code_char   = '0;
      res.sample_last = 1'b1;
      res.block_last  = cur.block_end;
      res.overflow    = 1'b1;
    end else begin
      res.code_char   = cm6_pkg::cm6_char(sym);
      res.sample_last = (rem == 3'd0);
      res.block_last  = (rem == 3'd0) && cur.block_end;
      res.overflow    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      code_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        code_valid <= emit;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (emit && last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_item <= res;
    end
    if (q_pop) begin
      cur   <= q_head;
      rem   <= q_head.last_idx;
      first <= 1'b1;
    end else if (emit) begin
      rem   <= rem - 3'd1;
      first <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/cm6_sample_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the CM6 sample encoder: configuration registers, front end, queue, back end.
// Depends on cm6_pkg, cm6_front, cm6_queue and cm6_back.
//
//   channel   handshake                payload
//   samp      samp_valid / samp_stall  samp_item  (cm6_pkg::samp_item_t)
//   code      code_valid / code_stall  code_item  (cm6_pkg::code_item_t)
//   cfg       cfg_we                   cfg_index, cfg_data
//
// A sample yields 1 to 6 output characters, one per cycle while the output is not stalled,
// or a single overflow result; the symbol emitter in the back end sets this rate.
// The front end takes one request per cycle until the job queue fills.
// A sample passes stages s1 and s2, the job queue and the back-end job register.
// Reset is synchronous and clears history, byte count and configuration.
// A stalled output holds the back end; the front end keeps working into the queue.

module cm6_sample_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  input  logic                samp_valid,
  output logic                samp_stall,
  input  cm6_pkg::samp_item_t samp_item,
  output logic                code_valid,
  input  logic                code_stall,
  output cm6_pkg::code_item_t code_item
);

  cm6_pkg::cfg_t cfg;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_nonempty;
  cm6_pkg::job_t q_job;
  cm6_pkg::job_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_order   <= cm6_pkg::ORDER_NONE;
      cfg.clip_enable  <= 1'b0;
      cfg.output_limit <= cm6_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cm6_pkg::REG_DIFF_ORDER:   cfg.diff_order   <= cfg_data[1:0];
        cm6_pkg::REG_CLIP_ENABLE:  cfg.clip_enable  <= cfg_data[0];
        cm6_pkg::REG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  cm6_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .samp_item  (samp_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  cm6_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  cm6_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("job popped from an empty queue");

  a_overflow_result: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_item.overflow |-> code_item.code_char == 7'd0 && code_item.sample_last)
    else $error("overflow result carries a character or is not the last of its sample");

  a_block_last_ends_sample: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_item.block_last |-> code_item.sample_last)
    else $error("block end flagged before the last character of a sample");

endmodule
